@@ sv/fbpa_pkg.sv @@
// ----------------------------------------------------------------------------
// fbpa_pkg - shared definitions for the fixed block pool allocator
// Sizes, codes, controller states and the command/status bundles that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

	localparam int MAX_BLOCKS    = 1024;
	localparam int ADDR_BITS     = 48;
	localparam int POINTER_BYTES = 8;

	localparam int BLOCK_W   = 17;
	localparam int POOL_W    = 32;
	localparam int OP_W      = 2;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam int IDX_W  = $clog2(MAX_BLOCKS);
	localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
	localparam int LINK_W = CNT_W;
	localparam int PROD_W = IDX_W + BLOCK_W;
	localparam int WIDE_W = (ADDR_BITS > POOL_W) ? ADDR_BITS : POOL_W;

	// end-of-list marker: one past the last block index
	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(MAX_BLOCKS);

	typedef enum logic [OP_W-1:0] {
		OP_INIT  = 2'd0,
		OP_ALLOC = 2'd1,
		OP_FREE  = 2'd2
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BASE  = 2'd0,
		REG_BLOCK = 2'd1,
		REG_POOL  = 2'd2
	} cfg_reg_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_RANGE  = 3'd2,
		ST_ALIGN  = 3'd3,
		ST_CONFIG = 3'd4,
		ST_NULL   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_FREE_RANGE,
		S_DIV_FREE,
		S_DIV_INIT,
		S_SWEEP,
		S_ALLOC,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic    load_in;        // latch the request beat
		logic    div_start;      // launch the divider
		logic    div_sel_free;   // divider operands: offset / live block size
		logic    alloc_pop;      // head <= next_link[head], count down
		logic    init_commit;    // latch live config, reset list head and counts
		logic    sweep_write;    // write one link of the init chain
		logic    free_push;      // next_link[idx] <= head, head <= idx
		logic    res_we;         // capture a result
		status_t res_status;
		logic    res_addr_alloc; // result address is the popped block
		logic    emit;           // move the result into the output register
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            addr_null;
		logic            cfg_bad;
		logic            head_null;
		logic            out_range;
		logic            div_done;
		logic            div_rem_nz;
		logic            quot_big;
		logic            quot_zero;
		logic            sweep_last;
		logic            out_free;
	} sts_t;

endpackage

`default_nettype wire

@@ sv/fbpa_req_if.sv @@
// ----------------------------------------------------------------------------
// fbpa_req_if - request channel of the pool allocator
// One beat carries an opcode and, for a free, the block address.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbpa_req_if;
	import fbpa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [OP_W-1:0]      opcode;
	logic [ADDR_BITS-1:0] block_address;

	modport source (output valid, output opcode, output block_address, input ready);
	modport sink   (input valid, input opcode, input block_address, output ready);
endinterface

`default_nettype wire

@@ sv/fbpa_rsp_if.sv @@
// ----------------------------------------------------------------------------
// fbpa_rsp_if - result channel of the pool allocator
// One beat per request: status, block address and free count.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbpa_rsp_if;
	import fbpa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [ADDR_BITS-1:0] result_address;
	logic [CNT_W-1:0]     blocks_free;

	modport source (output valid, output status, output result_address,
		output blocks_free, input ready);
	modport sink   (input valid, input status, input result_address,
		input blocks_free, output ready);
endinterface

`default_nettype wire

@@ sv/fbpa_cfg_if.sv @@
// ----------------------------------------------------------------------------
// fbpa_cfg_if - configuration write channel
// One beat writes one register, selected by index.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbpa_cfg_if;
	import fbpa_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [WIDE_W-1:0]    data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ sv/fbpa_ram.sv @@
// ----------------------------------------------------------------------------
// fbpa_ram - generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

@@ sv/fbpa_div.sv @@
// ----------------------------------------------------------------------------
// fbpa_div - iterative restoring divider
// One quotient bit per cycle; done pulses once quotient and remainder hold.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_div import fbpa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [POOL_W-1:0]  dividend,
	input  logic [BLOCK_W-1:0] divisor,
	output logic               done,
	output logic [POOL_W-1:0]  quot,
	output logic [BLOCK_W-1:0] rem
);

	localparam int ITER_W = $clog2(POOL_W + 1);

	logic [POOL_W-1:0]  acc_q;      // dividend shifts out, quotient shifts in
	logic [BLOCK_W-1:0] rem_q;
	logic [BLOCK_W-1:0] dvs_q;
	logic [ITER_W-1:0]  iter_q;
	logic               busy_q;
	logic               done_q;

	logic [BLOCK_W:0] trial;
	logic [BLOCK_W:0] diff;
	logic             take;

	assign trial = {rem_q, acc_q[POOL_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign take  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= ITER_W'(POOL_W);
			end else if (busy_q) begin
				iter_q <= iter_q - ITER_W'(1);
				if (iter_q == ITER_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[POOL_W-2:0], take};
			rem_q <= take ? diff[BLOCK_W-1:0] : trial[BLOCK_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = acc_q;
	assign rem  = rem_q;

endmodule

`default_nettype wire

@@ sv/fbpa_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbpa_ctrl - allocator sequencer
// Takes one request, steps the datapath through it, hands over the result.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ctrl import fbpa_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load_in = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				case (sts.op)
					OP_INIT: begin
						if (sts.cfg_bad) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_CONFIG;
							state_d        = S_EMIT;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV_INIT;
						end
					end
					OP_ALLOC: begin
						if (sts.head_null) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_EMPTY;
							state_d        = S_EMIT;
						end else begin
							state_d = S_ALLOC;
						end
					end
					OP_FREE: begin
						if (sts.addr_null) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_NULL;
							state_d        = S_EMIT;
						end else begin
							state_d = S_FREE_RANGE;
						end
					end
					default: begin
						// unused opcode: no change, plain ok
						cmd.res_we     = 1'b1;
						cmd.res_status = ST_OK;
						state_d        = S_EMIT;
					end
				endcase
			end
			S_FREE_RANGE: begin
				if (sts.out_range) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_RANGE;
					state_d        = S_EMIT;
				end else begin
					cmd.div_start    = 1'b1;
					cmd.div_sel_free = 1'b1;
					state_d          = S_DIV_FREE;
				end
			end
			S_DIV_FREE: begin
				if (sts.div_done) begin
					cmd.res_we = 1'b1;
					if (sts.div_rem_nz) begin
						cmd.res_status = ST_ALIGN;
					end else begin
						cmd.free_push  = 1'b1;
						cmd.res_status = ST_OK;
					end
					state_d = S_EMIT;
				end
			end
			S_DIV_INIT: begin
				if (sts.div_done) begin
					if (sts.div_rem_nz || sts.quot_big) begin
						cmd.res_we     = 1'b1;
						cmd.res_status = ST_CONFIG;
						state_d        = S_EMIT;
					end else begin
						cmd.init_commit = 1'b1;
						if (sts.quot_zero) begin
							cmd.res_we     = 1'b1;
							cmd.res_status = ST_OK;
							state_d        = S_EMIT;
						end else begin
							state_d = S_SWEEP;
						end
					end
				end
			end
			S_SWEEP: begin
				cmd.sweep_write = 1'b1;
				if (sts.sweep_last) begin
					cmd.res_we     = 1'b1;
					cmd.res_status = ST_OK;
					state_d        = S_EMIT;
				end
			end
			S_ALLOC: begin
				cmd.alloc_pop      = 1'b1;
				cmd.res_we         = 1'b1;
				cmd.res_status     = ST_OK;
				cmd.res_addr_alloc = 1'b1;
				state_d            = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/fbpa_dp.sv @@
// ----------------------------------------------------------------------------
// fbpa_dp - allocator datapath
// Config registers, live pool state, link RAM, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_dp import fbpa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cmd_t                 cmd,
	output sts_t                 sts,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WIDE_W-1:0]    cfg_data,
	input  logic [OP_W-1:0]      opcode,
	input  logic [ADDR_BITS-1:0] block_address,
	input  logic                 rsp_ready,
	output logic                 rsp_valid,
	output logic [STATUS_W-1:0]  status,
	output logic [ADDR_BITS-1:0] result_address,
	output logic [CNT_W-1:0]     blocks_free
);

	// programmed registers
	logic [ADDR_BITS-1:0] base_cfg_q;
	logic [BLOCK_W-1:0]   block_cfg_q;
	logic [POOL_W-1:0]    pool_cfg_q;

	// live pool state
	logic [ADDR_BITS-1:0] live_base_q;
	logic [BLOCK_W-1:0]   live_block_q;
	logic [POOL_W-1:0]    span_q;
	logic [CNT_W-1:0]     block_total_q;
	logic [CNT_W-1:0]     free_total_q;
	logic [LINK_W-1:0]    head_q;
	logic [CNT_W-1:0]     sweep_q;

	// request and working registers
	logic [OP_W-1:0]      op_q;
	logic [ADDR_BITS-1:0] addr_q;
	logic [ADDR_BITS-1:0] offset_q;
	logic [PROD_W-1:0]    prod_q;
	status_t              res_status_q;
	logic [ADDR_BITS-1:0] res_addr_q;

	// output register
	logic                 rsp_valid_q;
	logic [STATUS_W-1:0]  rsp_status_q;
	logic [ADDR_BITS-1:0] rsp_addr_q;
	logic [CNT_W-1:0]     rsp_free_q;

	logic                 div_done;
	logic [POOL_W-1:0]    div_quot;
	logic [BLOCK_W-1:0]   div_rem;
	logic [POOL_W-1:0]    div_dividend;
	logic [BLOCK_W-1:0]   div_divisor;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [LINK_W-1:0]    ram_wdata;
	logic [LINK_W-1:0]    ram_rdata;

	logic [CNT_W-1:0]     sweep_next;
	logic                 sweep_last;

	assign sweep_next = sweep_q + CNT_W'(1);
	assign sweep_last = sweep_next == block_total_q;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_cfg_q  <= '0;
			block_cfg_q <= '0;
			pool_cfg_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE:  base_cfg_q  <= cfg_data[ADDR_BITS-1:0];
				REG_BLOCK: block_cfg_q <= cfg_data[BLOCK_W-1:0];
				REG_POOL:  pool_cfg_q  <= cfg_data[POOL_W-1:0];
				default:   ;
			endcase
		end
	end

	// live pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_base_q   <= '0;
			live_block_q  <= '0;
			span_q        <= '0;
			block_total_q <= '0;
			free_total_q  <= '0;
			head_q        <= NULL_LINK;
			sweep_q       <= '0;
		end else begin
			if (cmd.init_commit) begin
				live_base_q   <= base_cfg_q;
				live_block_q  <= block_cfg_q;
				span_q        <= pool_cfg_q;   // exact multiple, so span = pool size
				block_total_q <= div_quot[CNT_W-1:0];
				free_total_q  <= div_quot[CNT_W-1:0];
				head_q        <= (div_quot == '0) ? NULL_LINK : '0;
				sweep_q       <= '0;
			end
			if (cmd.sweep_write) begin
				sweep_q <= sweep_next;
			end
			if (cmd.alloc_pop) begin
				head_q <= ram_rdata;
				if (free_total_q != '0) begin
					free_total_q <= free_total_q - CNT_W'(1);
				end
			end
			if (cmd.free_push) begin
				head_q <= LINK_W'(div_quot[IDX_W-1:0]);
				if (free_total_q != CNT_W'(MAX_BLOCKS)) begin
					free_total_q <= free_total_q + CNT_W'(1);
				end
			end
		end
	end

	// working registers; offset and product track their sources every cycle
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= opcode;
			addr_q <= block_address;
		end
		offset_q <= addr_q - live_base_q;
		prod_q   <= PROD_W'(head_q[IDX_W-1:0]) * PROD_W'(live_block_q);
		if (cmd.res_we) begin
			res_status_q <= cmd.res_status;
			res_addr_q   <= cmd.res_addr_alloc ? live_base_q + ADDR_BITS'(prod_q) : '0;
		end
	end

	// link RAM: init chain writes or a push
	assign ram_we    = cmd.sweep_write | cmd.free_push;
	assign ram_waddr = cmd.sweep_write ? sweep_q[IDX_W-1:0] : div_quot[IDX_W-1:0];
	assign ram_wdata = cmd.sweep_write ? (sweep_last ? NULL_LINK : LINK_W'(sweep_next))
		: head_q;

	fbpa_ram #(
		.WIDTH (LINK_W),
		.DEPTH (MAX_BLOCKS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (head_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	assign div_dividend = cmd.div_sel_free ? POOL_W'(offset_q) : pool_cfg_q;
	assign div_divisor  = cmd.div_sel_free ? live_block_q : block_cfg_q;

	fbpa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			rsp_status_q <= res_status_q;
			rsp_addr_q   <= res_addr_q;
			rsp_free_q   <= free_total_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_status_q;
	assign result_address = rsp_addr_q;
	assign blocks_free    = rsp_free_q;

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.addr_null  = addr_q == '0;
		sts.cfg_bad    = (base_cfg_q == '0) || (block_cfg_q < BLOCK_W'(POINTER_BYTES));
		sts.head_null  = head_q == NULL_LINK;
		sts.out_range  = WIDE_W'(offset_q) >= WIDE_W'(span_q);
		sts.div_done   = div_done;
		sts.div_rem_nz = div_rem != '0;
		sts.quot_big   = div_quot > POOL_W'(MAX_BLOCKS);
		sts.quot_zero  = div_quot == '0;
		sts.sweep_last = sweep_last;
		sts.out_free   = !rsp_valid_q || rsp_ready;
	end

endmodule

`default_nettype wire

@@ sv/fixed_block_pool_allocator_core.sv @@
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core - fixed-size block pool allocator
// LIFO free-list allocator over equal blocks of a buffer, one result per request.
// ----------------------------------------------------------------------------
// Program base address (index 0), block size (index 1) and pool size (index 2)
// on the cfg channel, then send an init request: it checks the settings (non-zero
// base, block size of at least one pointer, pool an exact multiple of the block,
// at most MAX_BLOCKS blocks), latches them and chains all blocks into the free
// list, block 0 at the head. Later register writes leave the live pool alone
// until the next init. Alloc pops the head block and returns its address; free
// pushes a block back after null, range and alignment checks. Double frees are
// not caught and can make the list cyclic; the free count saturates. Every
// request beat gives exactly one result beat carrying status, address and free
// count. Requests are handled one at a time, but a result waiting in the output
// register does not stop the next request being taken and worked on. An
// in-range free waits on the bit-serial divider that finds the block index and
// alignment; init runs the divider again and then the link RAM sweep, which
// writes one link per cycle. The link RAM needs no clearing after reset: an
// entry is only read once init has written it. cfg is always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_pool_allocator_core import fbpa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	fbpa_cfg_if.sink     cfg,
	fbpa_req_if.sink     req,
	fbpa_rsp_if.source   rsp
);

	cmd_t cmd;
	sts_t sts;
	logic cfg_we;

	// register writes never stall
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid && cfg.ready;

	// sequencer: one request in flight, waits at the end for the output register
	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: config, live pool state, link RAM, divider, result beat register
	fbpa_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.opcode         (req.opcode),
		.block_address  (req.block_address),
		.rsp_ready      (rsp.ready),
		.rsp_valid      (rsp.valid),
		.status         (rsp.status),
		.result_address (rsp.result_address),
		.blocks_free    (rsp.blocks_free)
	);

endmodule

`default_nettype wire

@@ sv/fbpa_checker.sv @@
// ----------------------------------------------------------------------------
// fbpa_checker - port-level checks for the pool allocator
// Watches request and result beats; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_checker import fbpa_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 req_valid,
	input logic                 req_ready,
	input logic                 rsp_valid,
	input logic                 rsp_ready,
	input logic [STATUS_W-1:0]  rsp_status,
	input logic [ADDR_BITS-1:0] rsp_result_address,
	input logic [CNT_W-1:0]     rsp_blocks_free
);

	logic       req_beat;
	logic       rsp_beat;
	logic [1:0] pending_q;   // request beats not yet answered

	assign req_beat = req_valid && req_ready;
	assign rsp_beat = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (req_beat && !rsp_beat) begin
			pending_q <= pending_q + 2'd1;
		end else if (rsp_beat && !req_beat) begin
			pending_q <= pending_q - 2'd1;
		end
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
			&& $stable(rsp_result_address) && $stable(rsp_blocks_free))
		else $error("result beat changed while stalled");

	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pending_q != 2'd0)
		else $error("result without an outstanding request");

	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		req_beat |-> pending_q < 2'd2)
		else $error("request taken while one is in work and one waits");

	a_addr_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != ST_OK |-> rsp_result_address == '0)
		else $error("non-zero address on a failed result");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_blocks_free <= CNT_W'(MAX_BLOCKS))
		else $error("free count beyond pool capacity");

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.req_valid          (req.valid),
	.req_ready          (req.ready),
	.rsp_valid          (rsp.valid),
	.rsp_ready          (rsp.ready),
	.rsp_status         (rsp.status),
	.rsp_result_address (rsp.result_address),
	.rsp_blocks_free    (rsp.blocks_free)
);

`default_nettype wire
